// ----- hdl/softened_pairwise_accel_2d_assert.svh -----
// Assertion macros shared by the accelerator RTL.
`ifndef SOFTENED_PAIRWISE_ACCEL_2D_ASSERT_SVH
`define SOFTENED_PAIRWISE_ACCEL_2D_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SPA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define SPA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// spa_pkg
// Types and fixed constants of the softened pairwise acceleration engine.
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int POS_W  = 32;
   localparam int MASS_W = 32;
   localparam int ACC_W  = 48;
   localparam int SOFT_W = 32;
   localparam int CNT_W  = 9;
   localparam int DIFF_W = 33;
   localparam int SQ_W   = 66;
   localparam int PROD_W = 65;
   localparam int NUM_W  = 95;
   localparam int DEN_W  = 66;
   localparam int QUO_W  = 63;
   localparam int STEP_W = 6;
   localparam int REQ_W  = 200;
   localparam int RSP_W  = 104;
   localparam int IDX_W  = 2;

   localparam logic [SOFT_W-1:0] SOFT_RESET = 32'd115292150;
   localparam logic [QUO_W-1:0]  TERM_CAP   = {1'b1, 62'd0};

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_SOURCE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [IDX_W-1:0] {
      REG_SOFTENING  = 2'd0,
      REG_DEST_COUNT = 2'd1,
      REG_SPARE2     = 2'd2,
      REG_SPARE3     = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LATCH,
      ST_MUL,
      ST_DEN,
      ST_DIV,
      ST_WB,
      ST_RESP
   } state_type;

endpackage

// ----- hdl/spa_div.sv -----
// ----------------------------------------------------------------------------
// spa_div
// Bit-serial restoring divider: 95-bit numerator over 66-bit denominator,
// one quotient bit a cycle, quotient capped at 2^62.
// ----------------------------------------------------------------------------
module spa_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [spa_pkg::NUM_W-1:0]  num,
   input  logic [spa_pkg::DEN_W-1:0]  den,
   output logic                       done,
   output logic [spa_pkg::QUO_W-1:0]  quo
);
   import spa_pkg::*;

   logic [DEN_W:0]       rem_ff, rem_in;
   logic [QUO_W-1:0]     low_ff, low_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ovf_ff, ovf_in;
   logic [DEN_W:0]       trial;
   logic                 fits;

   always_comb begin
      trial = {rem_ff[DEN_W-1:0], low_ff[QUO_W-1]};
      fits  = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      if (start) begin
         // quotient overflows 63 bits when the top part already reaches den
         ovf_in  = ({{(DEN_W-(NUM_W-QUO_W)){1'b0}}, num[NUM_W-1:QUO_W]} >= den);
         rem_in  = {{(DEN_W+1-(NUM_W-QUO_W)){1'b0}}, num[NUM_W-1:QUO_W]};
         low_in  = num[QUO_W-1:0];
         den_in  = den;
         quo_in  = '0;
         cnt_in  = STEP_W'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, den_ff}) : trial;
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign quo  = (ovf_ff || (quo_ff[QUO_W-1] && (|quo_ff[QUO_W-2:0]))) ? TERM_CAP : quo_ff;

endmodule

// ----- hdl/softened_pairwise_accel_2d.sv -----
// A load word is written as it is accepted; a read word passes the memory read register and
// the rsp register, held while rsp stalls. A source word updates min(dest_count, PARTICLES)
// slots in turn: read, latch, multiply, denominator, bit-serial divide, done, write back.
// The two per-axis dividers set the slot time; throughput is one item at a time.
// Reset (synchronous, active high) clears control state and dest_count and presets softening;
// the slot memory holds no defined value until loaded.
// ----------------------------------------------------------------------------
// softened_pairwise_accel_2d
// Direct 2D softened particle interaction engine over a slot memory.
// ----------------------------------------------------------------------------
module softened_pairwise_accel_2d #(
   parameter int PARTICLES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   // request stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // slot[7:0], pos_x[39:8], pos_y[71:40], mass[103:72],
   // init_acc_x[151:104], init_acc_y[199:152]
   input  logic [spa_pkg::REQ_W-1:0]    req_tdata,
   // mode[1:0]
   input  logic [1:0]                   req_tuser,
   // response stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // out_slot[7:0], acc_x[55:8], acc_y[103:56]
   output logic [spa_pkg::RSP_W-1:0]    rsp_tdata,
   // register write port
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [spa_pkg::IDX_W-1:0]    csr_index,
   input  logic [spa_pkg::SOFT_W-1:0]   csr_data
);
   import spa_pkg::*;

   localparam int AW    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
   localparam int CW    = $clog2(PARTICLES + 1);
   localparam int ENT_W = 2*POS_W + 2*ACC_W;

   // slot memory: {ay, ax, y, x}
   logic [ENT_W-1:0] mem [PARTICLES];
   logic [ENT_W-1:0] rd_q_ff;
   logic [AW-1:0]    mem_addr;
   logic             mem_we;
   logic [ENT_W-1:0] mem_wdata;

   state_type state_ff, state_in;

   logic [SOFT_W-1:0] soft_ff;
   logic [CNT_W-1:0]  dcount_ff;
   logic [CW-1:0]     j_ff, n_ff;
   logic [7:0]        slot_ff;
   logic [POS_W-1:0]  src_x_ff, src_y_ff;
   logic [MASS_W-1:0] mass_ff;
   logic [ACC_W-1:0]  ax_ff, ay_ff;
   logic [DIFF_W-1:0] ux_ff, uy_ff;
   logic              negx_ff, negy_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [PROD_W-1:0] prx_ff, pry_ff;
   logic              dzero_ff;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic              req_fire, csr_fire, rsp_load, div_start;
   logic              slot_ok, last_slot;
   logic [CW-1:0]     n_cap;
   logic [1:0]        req_mode;
   logic [7:0]        req_slot;
   logic [DEN_W-1:0]  den;
   logic [DIFF_W-1:0] dx, dy;
   logic              x_done, y_done;
   logic [QUO_W-1:0]  qx, qy;
   logic [63:0]       newx, newy;
   logic [ACC_W-1:0]  satx, saty;

   assign req_mode  = req_tuser;
   assign req_slot  = req_tdata[7:0];
   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign slot_ok   = (32'(slot_ff) < 32'(PARTICLES));
   assign n_cap     = (32'(dcount_ff) > 32'(PARTICLES)) ? CW'(PARTICLES) : CW'(dcount_ff);
   assign last_slot = ((j_ff + CW'(1)) == n_ff);

   // signed differences, destination minus source
   assign dx = $signed({rd_q_ff[POS_W-1], rd_q_ff[POS_W-1:0]})
             - $signed({src_x_ff[POS_W-1], src_x_ff});
   assign dy = $signed({rd_q_ff[2*POS_W-1], rd_q_ff[2*POS_W-1:POS_W]})
             - $signed({src_y_ff[POS_W-1], src_y_ff});
   assign den = sqx_ff + sqy_ff + SQ_W'(soft_ff);

   spa_div u_div_x (
      .clock (clock), .reset (reset), .start (div_start),
      .num   ({prx_ff, 30'd0}), .den (den), .done (x_done), .quo (qx)
   );
   spa_div u_div_y (
      .clock (clock), .reset (reset), .start (div_start),
      .num   ({pry_ff, 30'd0}), .den (den), .done (y_done), .quo (qy)
   );

   // subtract the signed term and saturate to 48 bits
   always_comb begin
      logic [63:0] tx, ty, lim_hi, lim_lo;
      lim_hi = 64'(48'h7FFF_FFFF_FFFF);
      lim_lo = {{16{1'b1}}, 48'h8000_0000_0000};
      tx = dzero_ff ? 64'd0 : (negx_ff ? -64'(qx) : 64'(qx));
      ty = dzero_ff ? 64'd0 : (negy_ff ? -64'(qy) : 64'(qy));
      newx = {{16{ax_ff[ACC_W-1]}}, ax_ff} - tx;
      newy = {{16{ay_ff[ACC_W-1]}}, ay_ff} - ty;
      satx = ($signed(newx) > $signed(lim_hi)) ? lim_hi[ACC_W-1:0]
           : ($signed(newx) < $signed(lim_lo)) ? lim_lo[ACC_W-1:0] : newx[ACC_W-1:0];
      saty = ($signed(newy) > $signed(lim_hi)) ? lim_hi[ACC_W-1:0]
           : ($signed(newy) < $signed(lim_lo)) ? lim_lo[ACC_W-1:0] : newy[ACC_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_mode)
                  MODE_SOURCE: state_in = (n_cap == '0) ? ST_IDLE : ST_READ;
                  MODE_READ:   state_in = ST_RESP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:  state_in = ST_LATCH;
         ST_LATCH: state_in = ST_MUL;
         ST_MUL:   state_in = ST_DEN;
         ST_DEN:   state_in = ST_DIV;
         ST_DIV:   state_in = (x_done && y_done) ? ST_WB : ST_DIV;
         ST_WB:    state_in = last_slot ? ST_IDLE : ST_READ;
         ST_RESP:  state_in = rsp_load ? ST_IDLE : ST_RESP;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      mem_addr   = j_ff[AW-1:0];
      mem_we     = 1'b0;
      mem_wdata  = {satx ^ satx ^ ay_ff, ax_ff, rd_q_ff[2*POS_W-1:0]};
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            mem_addr   = AW'(req_slot);
            // load: write the slot when it lies in the table
            mem_we     = req_fire && (req_mode == MODE_LOAD)
                         && (32'(req_slot) < 32'(PARTICLES));
            mem_wdata  = {req_tdata[199:152], req_tdata[151:104],
                          req_tdata[71:40], req_tdata[39:8]};
         end
         ST_DEN:  div_start = 1'b1;
         ST_WB: begin
            mem_we    = 1'b1;
            mem_wdata = {saty, satx, rd_q_ff[2*POS_W-1:0]};
         end
         ST_RESP: begin
            mem_addr = AW'(slot_ff);
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_q_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         soft_ff      <= SOFT_RESET;
         dcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            case (csr_index)
               REG_SOFTENING:  soft_ff   <= csr_data;
               REG_DEST_COUNT: dcount_ff <= csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         // advance the slot walk
         if (state_ff == ST_IDLE) begin
            j_ff <= '0;
         end else if (state_ff == ST_WB) begin
            j_ff <= j_ff + CW'(1);
         end
      end
      // payload
      if (req_fire) begin
         slot_ff  <= req_slot;
         src_x_ff <= req_tdata[39:8];
         src_y_ff <= req_tdata[71:40];
         mass_ff  <= req_tdata[103:72];
         n_ff     <= n_cap;
      end
      if (state_ff == ST_LATCH) begin
         ax_ff   <= rd_q_ff[2*POS_W+ACC_W-1:2*POS_W];
         ay_ff   <= rd_q_ff[ENT_W-1:2*POS_W+ACC_W];
         negx_ff <= dx[DIFF_W-1];
         negy_ff <= dy[DIFF_W-1];
         ux_ff   <= dx[DIFF_W-1] ? -dx : dx;
         uy_ff   <= dy[DIFF_W-1] ? -dy : dy;
      end
      if (state_ff == ST_MUL) begin
         sqx_ff <= SQ_W'(ux_ff) * SQ_W'(ux_ff);
         sqy_ff <= SQ_W'(uy_ff) * SQ_W'(uy_ff);
         prx_ff <= PROD_W'(mass_ff) * PROD_W'(ux_ff);
         pry_ff <= PROD_W'(mass_ff) * PROD_W'(uy_ff);
      end
      if (state_ff == ST_DEN) begin
         // coincident points with no softening give no term
         dzero_ff <= (den == '0);
      end
      if (rsp_load) begin
         rsp_data_ff <= {slot_ok ? rd_q_ff[ENT_W-1:2*POS_W+ACC_W] : {ACC_W{1'b0}},
                         slot_ok ? rd_q_ff[2*POS_W+ACC_W-1:2*POS_W] : {ACC_W{1'b0}},
                         slot_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "softened_pairwise_accel_2d_assert.svh"

   `SPA_ASSERT_IMP(a_we_place, clock, reset, mem_we, (state_ff == ST_WB) || (state_ff == ST_IDLE && req_fire && req_mode == MODE_LOAD), "slot memory written outside load or write back")
   `SPA_ASSERT_IMP(a_walk_range, clock, reset, state_ff == ST_READ, j_ff < n_ff, "slot walk ran past the count")
   `SPA_ASSERT_NXT(a_div_hold, clock, reset, state_ff == ST_DIV, state_ff == ST_DIV || state_ff == ST_WB, "divide left without write back")
   `SPA_ASSERT_IMP(a_div_pair, clock, reset, x_done, y_done, "axis dividers out of step")

endmodule
